[src/ggs_pkg.sv]
// shared types and constants for the grid gradient stencil
package ggs_pkg;

    localparam int GRID_SIZE_DEFAULT = 64;

    localparam logic KIND_SAMPLE = 1'b0;
    localparam logic KIND_FLUSH  = 1'b1;

    typedef struct packed {
        logic               kind;
        logic signed [15:0] potential;
    } in_item_t;

    typedef struct packed {
        logic signed [15:0] grad_x;
        logic signed [15:0] grad_y;
        logic [5:0]         out_row;
        logic [5:0]         out_col;
        logic               frame_last;
    } out_item_t;

endpackage

[src/grid_gradient_stencil.sv]
// central-difference gradient of a square grid streamed in raster order
//
// user notes: samples of a GRID_SIZE x GRID_SIZE grid arrive in raster order, one
// transaction per cycle unless stalled, and each grid point's gradient leaves one row
// behind the input; the last row is drained by GRID_SIZE flush transactions once the
// whole grid has arrived. one transaction is accepted every cycle unless stalled, and
// its result, if any, is registered, in the skid register while the output is held;
// a two-deep output stage (result register plus skid register) lets input continue
// while a result waits, and sample_stall rises only while the skid register is
// occupied. the two line stores are single-write, single-read memories with registered
// read data, read ahead along the row so that the stencil window sits in registers at
// acceptance. the line stores need no clearing pass: an entry is always written before
// its value is used. out_row and out_col carry the low six bits of the indices
module grid_gradient_stencil #(
    parameter int GRID_SIZE = ggs_pkg::GRID_SIZE_DEFAULT
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              sample_valid,
    output logic              sample_stall,
    input  ggs_pkg::in_item_t sample,
    output logic              grad_valid,
    input  logic              grad_stall,
    output ggs_pkg::out_item_t grad
);

    localparam int COL_W = $clog2(GRID_SIZE);
    localparam int ROW_W = $clog2(GRID_SIZE + 1);

    // line stores
    logic signed [15:0] mid_mem [GRID_SIZE];
    logic signed [15:0] up_mem  [GRID_SIZE];

    // stencil window: left and centre in registers, right and up from read data
    logic signed [15:0] win_l_reg;
    logic signed [15:0] win_c_reg;
    logic signed [15:0] mid_rd_reg;
    logic signed [15:0] up_rd_reg;

    logic [ROW_W-1:0] in_row_reg;
    logic [COL_W-1:0] in_col_reg;

    // output register and skid register
    logic               out_valid_reg;
    ggs_pkg::out_item_t out_data_reg;
    logic               skid_valid_reg;
    ggs_pkg::out_item_t skid_data_reg;

    logic               accept;
    logic               sample_ok;
    logic               flush_ok;
    logic               shift_en;
    logic               has_result;
    logic               col_last;
    logic               row_full;
    logic [COL_W:0]     col_p1;
    logic [COL_W:0]     col_p2;
    logic [COL_W-1:0]   addr_up;
    logic [COL_W-1:0]   addr_mid;
    logic [ROW_W-1:0]   row_idx;
    logic [ROW_W+5:0]   row_ext;
    logic [COL_W+5:0]   col_ext;

    logic               up_in;
    logic               dn_in;
    logic               lf_in;
    logic               rt_in;
    logic signed [15:0] ctr;
    logic signed [15:0] up_v;
    logic signed [15:0] dn_v;
    logic signed [15:0] lf_v;
    logic signed [15:0] rt_v;
    logic signed [15:0] uy;
    logic signed [15:0] dy;
    logic signed [15:0] lx;
    logic signed [15:0] rx;
    logic signed [16:0] dx;
    logic signed [16:0] dyy;
    ggs_pkg::out_item_t result;

    logic               out_take;

    assign sample_stall = skid_valid_reg;
    assign accept       = sample_valid && !sample_stall;

    assign row_full  = (in_row_reg == ROW_W'(GRID_SIZE));
    assign col_last  = (in_col_reg == COL_W'(GRID_SIZE - 1));
    assign sample_ok = (sample.kind == ggs_pkg::KIND_SAMPLE) && !row_full;
    assign flush_ok  = (sample.kind == ggs_pkg::KIND_FLUSH) && row_full;
    assign shift_en  = accept && (sample_ok || flush_ok);
    // no result while row zero arrives
    assign has_result = (sample_ok && (in_row_reg != '0)) || flush_ok;

    // read-ahead addresses: upper one column ahead, middle two ahead, wrapping
    always_comb
    begin
        col_p1 = {1'b0, in_col_reg} + (COL_W + 1)'(1);
        col_p2 = {1'b0, in_col_reg} + (COL_W + 1)'(2);
        if (col_p1 >= (COL_W + 1)'(GRID_SIZE))
        begin
            col_p1 = col_p1 - (COL_W + 1)'(GRID_SIZE);
        end
        if (col_p2 >= (COL_W + 1)'(GRID_SIZE))
        begin
            col_p2 = col_p2 - (COL_W + 1)'(GRID_SIZE);
        end
        addr_up  = col_p1[COL_W-1:0];
        addr_mid = col_p2[COL_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (shift_en)
        begin
            if (sample_ok)
            begin
                mid_mem[in_col_reg] <= sample.potential;
                up_mem[in_col_reg]  <= win_c_reg;
            end
            mid_rd_reg <= mid_mem[addr_mid];
            up_rd_reg  <= up_mem[addr_up];
            win_l_reg  <= win_c_reg;
            win_c_reg  <= mid_rd_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_row_reg <= '0;
            in_col_reg <= '0;
        end
        else if (shift_en)
        begin
            if (col_last)
            begin
                in_col_reg <= '0;
                if (sample_ok)
                begin
                    in_row_reg <= in_row_reg + ROW_W'(1);
                end
                else
                begin
                    // drain done, ready for the next frame
                    in_row_reg <= '0;
                end
            end
            else
            begin
                in_col_reg <= in_col_reg + COL_W'(1);
            end
        end
    end

    // stencil arithmetic
    always_comb
    begin
        ctr  = win_c_reg;
        up_v = up_rd_reg;
        dn_v = sample.potential;
        lf_v = win_l_reg;
        rt_v = mid_rd_reg;

        up_in = sample_ok ? (in_row_reg >= ROW_W'(2)) : 1'b1;
        dn_in = sample_ok;
        lf_in = (in_col_reg != '0);
        rt_in = !col_last;

        // mirror missing neighbours from the opposite side
        uy = up_in ? up_v : dn_v;
        dy = dn_in ? dn_v : up_v;
        lx = lf_in ? lf_v : rt_v;
        rx = rt_in ? rt_v : lf_v;

        // zero neighbour takes the centre, first match only
        if (dn_in && dn_v == 16'sd0)
        begin
            dy = ctr;
        end
        else if (up_in && up_v == 16'sd0)
        begin
            uy = ctr;
        end
        else if (rt_in && rt_v == 16'sd0)
        begin
            rx = ctr;
        end
        else if (lf_in && lf_v == 16'sd0)
        begin
            lx = ctr;
        end

        dx  = {lx[15], lx} - {rx[15], rx};
        dyy = {uy[15], uy} - {dy[15], dy};

        row_idx = sample_ok ? (in_row_reg - ROW_W'(1)) : ROW_W'(GRID_SIZE - 1);
        row_ext = {6'b0, row_idx};
        col_ext = {6'b0, in_col_reg};

        result.grad_x     = (ctr == 16'sd0) ? 16'sd0 : dx[16:1];
        result.grad_y     = (ctr == 16'sd0) ? 16'sd0 : dyy[16:1];
        result.out_row    = row_ext[5:0];
        result.out_col    = col_ext[5:0];
        result.frame_last = flush_ok && col_last;
    end

    // output register with skid
    assign out_take = out_valid_reg && !grad_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (out_take)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (accept && has_result)
        begin
            if (out_valid_reg && !out_take)
            begin
                skid_valid_reg <= 1'b1;
            end
            else
            begin
                out_valid_reg <= 1'b1;
            end
        end
        else if (out_take)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (out_take)
            begin
                out_data_reg <= skid_data_reg;
            end
        end
        else if (accept && has_result)
        begin
            if (out_valid_reg && !out_take)
            begin
                skid_data_reg <= result;
            end
            else
            begin
                out_data_reg <= result;
            end
        end
    end

    assign grad_valid = out_valid_reg;
    assign grad       = out_data_reg;

endmodule

[bench/tb_grid_gradient_stencil.sv]
// self-checking testbench for the grid gradient stencil
`timescale 1ns / 1ps

module tb_grid_gradient_stencil;

    // grid edge length, kept at the block's default
    localparam int GRID        = ggs_pkg::GRID_SIZE_DEFAULT;
    localparam int HALF_PERIOD = 4;
    localparam int RESET_CYCLES = 12;
    // number of grid rows streamed after the opening flush transactions
    localparam int ROWS        = 22;
    // receiver hold-off long enough to back the block up into its input
    localparam int HOLD_CYCLES = 300;
    // cycles allowed for the output registers to settle at the end
    localparam int DRAIN_CYCLES = 16;
    // about 1.5k transactions, each at worst the longest sender gap plus the longest
    // receiver stall, plus the hold-off, taken several times over
    localparam int CYCLE_LIMIT = 1_000_000;

    localparam logic signed [15:0] POT_MAX = 16'sh7FFF;
    localparam logic signed [15:0] POT_MIN = 16'sh8000;

    logic               clk          = 1'b0;
    logic               rst_n        = 1'b0;
    logic               sample_valid = 1'b0;
    logic               sample_stall;
    ggs_pkg::in_item_t  sample       = '0;
    logic               grad_valid;
    logic               grad_stall   = 1'b0;
    ggs_pkg::out_item_t grad;

    // stimulus waiting to be offered, and gradients waiting to come out
    ggs_pkg::in_item_t  samples_queued[$];
    ggs_pkg::out_item_t gradients_due[$];

    // local copy of the stencil state
    logic signed [15:0] upper_line[GRID];
    logic signed [15:0] middle_line[GRID];
    logic signed [15:0] left_prev = '0;
    int                 row_in    = 0;
    int                 col_in    = 0;

    int   total_items   = 0;
    int   taken         = 0;
    int   flushes_taken = 0;
    int   checked       = 0;
    int   errors        = 0;
    int   cycle_count   = 0;
    int   send_gap      = 0;
    int   stall_left    = 0;
    logic hold_off      = 1'b0;

    grid_gradient_stencil #(
        .GRID_SIZE (GRID)
    ) u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample       (sample),
        .grad_valid   (grad_valid),
        .grad_stall   (grad_stall),
        .grad         (grad)
    );

    always #(HALF_PERIOD) clk = ~clk;

    // ------------------------------------------------------------------
    // gradient predictor
    // ------------------------------------------------------------------

    // floor halving of a 17-bit difference, always fits 16 bits
    function automatic logic signed [15:0] halve(input logic signed [16:0] d);
        logic signed [16:0] shifted;
        shifted = d >>> 1;
        return shifted[15:0];
    endfunction

    // one stencil point: mirror missing neighbours, then apply the first
    // zero-neighbour substitution in the order down, up, right, left
    function automatic ggs_pkg::out_item_t stencil_point(
        input int r, input int c, input logic signed [15:0] ctr,
        input bit up_ok, input logic signed [15:0] up,
        input bit dn_ok, input logic signed [15:0] dn,
        input bit lf_ok, input logic signed [15:0] lf,
        input bit rt_ok, input logic signed [15:0] rt);
        logic signed [15:0] uy, dy, lx, rx;
        ggs_pkg::out_item_t o;
        uy = up_ok ? up : dn;
        dy = dn_ok ? dn : up;
        lx = lf_ok ? lf : rt;
        rx = rt_ok ? rt : lf;
        if (dn_ok && dn == 0)
            dy = ctr;
        else if (up_ok && up == 0)
            uy = ctr;
        else if (rt_ok && rt == 0)
            rx = ctr;
        else if (lf_ok && lf == 0)
            lx = ctr;
        // a zero centre forces both components to zero
        o.grad_x     = (ctr != 0) ? halve(17'(lx) - 17'(rx)) : '0;
        o.grad_y     = (ctr != 0) ? halve(17'(uy) - 17'(dy)) : '0;
        o.out_row    = 6'(r);
        o.out_col    = 6'(c);
        o.frame_last = (r == GRID - 1) && (c == GRID - 1);
        return o;
    endfunction

    // advance the stencil state by one accepted transaction
    task automatic predict_gradient(input ggs_pkg::in_item_t it, output bit produced,
                                    output ggs_pkg::out_item_t res);
        int                 c;
        bit                 lf_ok;
        bit                 rt_ok;
        logic signed [15:0] lf;
        logic signed [15:0] rt;
        produced = 1'b0;
        res      = '0;
        c        = col_in;
        rt_ok    = (c + 1 < GRID);
        rt       = rt_ok ? middle_line[c + 1] : '0;
        if (it.kind == ggs_pkg::KIND_SAMPLE)
        begin
            // samples are dropped once the whole grid has arrived
            if (row_in < GRID)
            begin
                // the row above the incoming one becomes computable
                if (row_in >= 1)
                begin
                    res = stencil_point(row_in - 1, c, middle_line[c],
                                        row_in >= 2, upper_line[c],
                                        1'b1, it.potential,
                                        c >= 1, left_prev, rt_ok, rt);
                    produced = 1'b1;
                end
                left_prev      = middle_line[c];
                upper_line[c]  = middle_line[c];
                middle_line[c] = it.potential;
                c++;
                if (c >= GRID)
                begin
                    c = 0;
                    row_in++;
                end
                col_in = c;
            end
        end
        else if (row_in >= GRID)
        begin
            // drain of the last row: no row below, mirrored from above
            lf_ok = (c >= 1);
            lf    = lf_ok ? middle_line[c - 1] : '0;
            res = stencil_point(GRID - 1, c, middle_line[c],
                                1'b1, upper_line[c], 1'b0, '0,
                                lf_ok, lf, rt_ok, rt);
            produced = 1'b1;
            c++;
            if (c >= GRID)
            begin
                c      = 0;
                row_in = 0;
            end
            col_in = c;
        end
        // a flush before the grid is complete changes nothing
    endtask

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------

    // mostly short gaps, some medium, a few long; none in quiet stretches
    function automatic int pick_gap(input bit quiet);
        int roll;
        roll = $urandom_range(0, 99);
        if (quiet || roll < 55)
            return 0;
        if (roll < 88)
            return $urandom_range(1, 3);
        if (roll < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // zeros and extremes weighted up so every substitution rule fires often
    function automatic logic signed [15:0] random_potential();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 12)
            return '0;
        if (roll < 16)
        begin
            case ($urandom_range(0, 3))
                0:       return POT_MAX;
                1:       return POT_MIN;
                2:       return 16'sd1;
                default: return -16'sd1;
            endcase
        end
        return 16'($urandom);
    endfunction

    // hand-placed patterns in the top rows, random values elsewhere
    function automatic logic signed [15:0] frame_value(input int r, input int c);
        if (r == 1 && c < 16)
            // pairs of extremes give the largest horizontal swings both ways
            return ((c >> 1) & 1) ? POT_MIN : POT_MAX;
        if (r <= 2 && c >= 16 && c < 24)
            return (r == 0) ? POT_MAX : (r == 2) ? POT_MIN : 16'sd12345;
        if (r <= 2 && c >= 24 && c < 32)
            return (r == 0) ? POT_MIN : (r == 2) ? POT_MAX : -16'sd4321;
        if (r <= 2 && c >= 40 && c < 50)
        begin
            // zero centre, zero below, zero above, zero right and left of
            // neighbours, and zero both above and below (only below applies)
            if ((r == 1 && c == 40) || (r == 2 && c == 41) || (r == 0 && c == 42)
                || (r == 1 && c == 44) || (r != 1 && c == 48))
                return '0;
            return 16'(100 + 37 * c - 250 * r);
        end
        return random_potential();
    endfunction

    task automatic queue_item(input logic kind, input logic signed [15:0] pot);
        ggs_pkg::in_item_t it;
        it.kind      = kind;
        it.potential = pot;
        samples_queued.push_back(it);
    endtask

    task automatic report_fault(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        errors++;
    endtask

    // ------------------------------------------------------------------
    // stimulus build, reset and end of run
    // ------------------------------------------------------------------
    initial
    begin
        for (int i = 0; i < GRID; i++)
        begin
            upper_line[i]  = '0;
            middle_line[i] = '0;
        end

        // early flush transactions, all ignored while the grid is empty
        queue_item(ggs_pkg::KIND_FLUSH, '0);
        queue_item(ggs_pkg::KIND_FLUSH, POT_MAX);
        queue_item(ggs_pkg::KIND_FLUSH, POT_MIN);
        queue_item(ggs_pkg::KIND_FLUSH, -16'sd1);

        for (int r = 0; r < ROWS; r++)
        begin
            for (int c = 0; c < GRID; c++)
            begin
                // occasional stray flush inside the grid, ignored by the block
                if ($urandom_range(0, 99) < 2)
                    queue_item(ggs_pkg::KIND_FLUSH, random_potential());
                queue_item(ggs_pkg::KIND_SAMPLE, frame_value(r, c));
            end
        end
        total_items = samples_queued.size();

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (taken != total_items)
            @(posedge clk);
        while (gradients_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("streamed %0d transactions (%0d flush) over the top %0d grid rows",
                 taken, flushes_taken, ROWS);
        $display("compared %0d gradients, %0d mismatches", checked, errors);
        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // receiver hold-off once results are flowing, long enough that the
    // output stage and skid fill and the block stalls its input
    initial
    begin
        while (taken < 600)
            @(posedge clk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off <= 1'b0;
    end

    // ------------------------------------------------------------------
    // driver: offers queued transactions with random gaps
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_valid <= 1'b0;
            sample       <= '0;
            send_gap     <= 0;
        end
        else if (!sample_valid || !sample_stall)
        begin
            // gaps are skipped during the hold-off so the block backs up
            if (send_gap > 0 && !hold_off)
            begin
                sample_valid <= 1'b0;
                send_gap     <= send_gap - 1;
            end
            else if (samples_queued.size() != 0)
            begin
                sample       <= samples_queued.pop_front();
                sample_valid <= 1'b1;
                send_gap     <= pick_gap(((taken / 400) % 4) == 3);
            end
            else
            begin
                sample_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // receiver: random stall, with quiet stretches and the long hold-off
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        int n;
        if (!rst_n)
        begin
            grad_stall <= 1'b0;
            stall_left <= 0;
        end
        else if (hold_off)
        begin
            grad_stall <= 1'b1;
        end
        else if (stall_left > 0)
        begin
            grad_stall <= 1'b1;
            stall_left <= stall_left - 1;
        end
        else
        begin
            n = pick_gap(((cycle_count / 1500) % 4) == 2);
            grad_stall <= (n != 0);
            stall_left <= (n != 0) ? n - 1 : 0;
        end
    end

    // ------------------------------------------------------------------
    // monitor: predicts on each input transaction, checks each output one
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        bit                 produced;
        ggs_pkg::out_item_t due;
        ggs_pkg::out_item_t want;
        if (rst_n)
        begin
            if (sample_valid && !sample_stall)
            begin
                predict_gradient(sample, produced, due);
                if (produced)
                    gradients_due.push_back(due);
                taken <= taken + 1;
                if (sample.kind == ggs_pkg::KIND_FLUSH)
                    flushes_taken <= flushes_taken + 1;
            end
            if (grad_valid && !grad_stall)
            begin
                if (gradients_due.size() == 0)
                begin
                    report_fault($sformatf("gradient at (%0d,%0d) with none pending",
                                           grad.out_row, grad.out_col));
                end
                else
                begin
                    want = gradients_due.pop_front();
                    if (grad.grad_x !== want.grad_x)
                        report_fault($sformatf("grad_x at (%0d,%0d): got %0d, expected %0d",
                                               want.out_row, want.out_col,
                                               grad.grad_x, want.grad_x));
                    if (grad.grad_y !== want.grad_y)
                        report_fault($sformatf("grad_y at (%0d,%0d): got %0d, expected %0d",
                                               want.out_row, want.out_col,
                                               grad.grad_y, want.grad_y));
                    if (grad.out_row !== want.out_row)
                        report_fault($sformatf("out_row: got %0d, expected %0d",
                                               grad.out_row, want.out_row));
                    if (grad.out_col !== want.out_col)
                        report_fault($sformatf("out_col: got %0d, expected %0d",
                                               grad.out_col, want.out_col));
                    if (grad.frame_last !== want.frame_last)
                        report_fault($sformatf("frame_last at (%0d,%0d): got %0b, expected %0b",
                                               want.out_row, want.out_col,
                                               grad.frame_last, want.frame_last));
                    checked++;
                end
            end
        end
    end

    // cycle counter with a hard limit on the run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d gradients still pending",
                     cycle_count, gradients_due.size());
            $display("CHECK FAILED");
            $finish;
        end
    end

endmodule

[files.f]
src/ggs_pkg.sv
src/grid_gradient_stencil.sv
bench/tb_grid_gradient_stencil.sv
